FILE: hdl/ldwv_pkg.sv
// ----------------------------------------------------------------------------
// ldwv_pkg
// shared types and constants of the landing detector window variance block
// ----------------------------------------------------------------------------
`default_nettype none

package ldwv_pkg;

   // field widths
   localparam int ALT_W      = 24;
   localparam int THRUST_W   = 16;
   localparam int THR_W      = 16;
   localparam int SQ_MAG_W   = 2 * ALT_W - 1;   // square of a 24 bit magnitude

   // default block parameters
   localparam int WINDOW_LEN_DEFAULT      = 30;
   localparam int CONFIRM_SECONDS_DEFAULT = 3;

   // fixed constants of the algorithm
   localparam int REF_STEP_MM   = 5000;
   localparam int MM_PER_SECOND = 1000;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [THR_W-1:0]    SPEED_THRESHOLD_RESET   = 16'd300;
   localparam logic [THRUST_W-1:0] ACTIVATION_THRUST_RESET = 16'd32768;
   localparam logic [ALT_W-1:0]    INITIAL_REFERENCE_RESET = 24'd0;

   typedef enum logic [1:0] {
      CSR_SPEED_THRESHOLD   = 2'd0,
      CSR_ACTIVATION_THRUST = 2'd1,
      CSR_INITIAL_REFERENCE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]    speed_threshold;
      logic [THRUST_W-1:0] activation_thrust;
   } cfg_type;

   typedef struct packed {
      logic                    load;
      logic signed [ALT_W-1:0] value;
   } ref_load_type;

endpackage

`default_nettype wire

FILE: hdl/ldwv_channels.sv
// ----------------------------------------------------------------------------
// ldwv channels
// valid/ready channels for sample transactions and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface ldwv_req_if import ldwv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ALT_W-1:0] altitude;
   logic [THRUST_W-1:0]     thrust;
   logic                    sample_due;

   modport source (output valid, altitude, thrust, sample_due, input ready);
   modport sink   (input valid, altitude, thrust, sample_due, output ready);
endinterface

interface ldwv_rsp_if import ldwv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    landed;
   logic                    reference_update;
   logic signed [ALT_W-1:0] reference_altitude;

   modport source (output valid, landed, reference_update, reference_altitude, input ready);
   modport sink   (input valid, landed, reference_update, reference_altitude, output ready);
endinterface

`default_nettype wire

FILE: hdl/ldwv_csr.sv
// ----------------------------------------------------------------------------
// ldwv_csr
// apb register file, plus the squared speed threshold limit for the variance test
// ----------------------------------------------------------------------------
`default_nettype none

module ldwv_csr import ldwv_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg,
   output logic [SQ_MAG_W+2*$clog2(WINDOW_LEN+1)-1:0] limit,
   output ref_load_type               ref_load
);

   localparam int CMP_W  = SQ_MAG_W + 2 * $clog2(WINDOW_LEN + 1);
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int SCL_W  = THR_W + CNT_W;
   localparam logic [CMP_W-1:0] LIMIT_RESET =
      CMP_W'(WINDOW_LEN * WINDOW_LEN)
      * CMP_W'(int'(SPEED_THRESHOLD_RESET) * int'(SPEED_THRESHOLD_RESET));

   logic                    write_en;
   csr_index_type           index;
   logic [THR_W-1:0]        speed_ff, speed_in;
   logic [THRUST_W-1:0]     thrust_ff, thrust_in;
   logic [ALT_W-1:0]        init_ref_ff, init_ref_in;
   logic [SCL_W-1:0]        scaled_thr;
   logic [2*SCL_W-1:0]      limit_sq;
   logic [CMP_W-1:0]        limit_ff, limit_in;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      speed_in    = speed_ff;
      thrust_in   = thrust_ff;
      init_ref_in = init_ref_ff;
      if (write_en) begin
         case (index)
            CSR_SPEED_THRESHOLD:   speed_in    = csr_pwdata[THR_W-1:0];
            CSR_ACTIVATION_THRUST: thrust_in   = csr_pwdata[THRUST_W-1:0];
            CSR_INITIAL_REFERENCE: init_ref_in = csr_pwdata[ALT_W-1:0];
            default: ;
         endcase
      end
   end

   // limit = (n*thr)^2, taken in on the same edge as the threshold
   assign scaled_thr = SCL_W'(speed_in) * SCL_W'(WINDOW_LEN);
   assign limit_sq   = scaled_thr * scaled_thr;
   assign limit_in   = CMP_W'(limit_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= SPEED_THRESHOLD_RESET;
         thrust_ff   <= ACTIVATION_THRUST_RESET;
         init_ref_ff <= INITIAL_REFERENCE_RESET;
         limit_ff    <= LIMIT_RESET;
      end else begin
         speed_ff    <= speed_in;
         thrust_ff   <= thrust_in;
         init_ref_ff <= init_ref_in;
         limit_ff    <= limit_in;
      end
   end

   always_comb begin
      case (index)
         CSR_SPEED_THRESHOLD:   csr_prdata = CSR_DATA_W'(speed_ff);
         CSR_ACTIVATION_THRUST: csr_prdata = CSR_DATA_W'(thrust_ff);
         CSR_INITIAL_REFERENCE: csr_prdata = CSR_DATA_W'($signed(init_ref_ff));
         default:               csr_prdata = '0;
      endcase
   end

   assign cfg.speed_threshold   = speed_ff;
   assign cfg.activation_thrust = thrust_ff;
   assign limit                 = limit_ff;
   assign ref_load.load         = write_en && (index == CSR_INITIAL_REFERENCE);
   assign ref_load.value        = csr_pwdata[ALT_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/ldwv_window.sv
// ----------------------------------------------------------------------------
// ldwv_window
// sample ring with running sum and sum of squares
// ----------------------------------------------------------------------------
`default_nettype none

module ldwv_window import ldwv_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic                    clear,
   input  wire logic signed [ALT_W-1:0] alt,
   input  wire logic [SQ_MAG_W-1:0]     alt_sq,
   output logic signed [ALT_W+$clog2(WINDOW_LEN)-1:0] sum,
   output logic [SQ_MAG_W+$clog2(WINDOW_LEN)-1:0]     sq_sum,
   output logic                         full
);

   localparam int PTR_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = ALT_W + PTR_W;
   localparam int SQ_W  = SQ_MAG_W + PTR_W;

   logic signed [ALT_W-1:0] ring_alt_ff [WINDOW_LEN];
   logic [SQ_MAG_W-1:0]     ring_sq_ff  [WINDOW_LEN];

   logic [PTR_W-1:0]        wp_ff, wp_in, base_wp;
   logic [CNT_W-1:0]        count_ff, count_in, base_count;
   logic signed [SUM_W-1:0] sum_ff, sum_in, base_sum;
   logic [SQ_W-1:0]         sq_ff, sq_in, base_sq;
   logic                    base_full;
   logic signed [ALT_W-1:0] old_alt;
   logic [SQ_MAG_W-1:0]     old_sq;

   // a landing of the previous transaction clears the window first
   assign base_wp    = clear ? '0 : wp_ff;
   assign base_count = clear ? '0 : count_ff;
   assign base_sum   = clear ? '0 : sum_ff;
   assign base_sq    = clear ? '0 : sq_ff;
   assign base_full  = (base_count == CNT_W'(WINDOW_LEN));

   assign old_alt = ring_alt_ff[base_wp];
   assign old_sq  = ring_sq_ff[base_wp];

   always_comb begin
      wp_in    = base_wp;
      count_in = base_count;
      sum_in   = base_sum;
      sq_in    = base_sq;
      if (push) begin
         sum_in = base_sum + SUM_W'(alt);
         sq_in  = base_sq + SQ_W'(alt_sq);
         if (base_full) begin
            sum_in = sum_in - SUM_W'(old_alt);
            sq_in  = sq_in - SQ_W'(old_sq);
         end else begin
            count_in = base_count + CNT_W'(1);
         end
         wp_in = (base_wp == PTR_W'(WINDOW_LEN - 1)) ? '0 : base_wp + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ring_alt_ff[base_wp] <= alt;
         ring_sq_ff[base_wp]  <= alt_sq;
      end
   end

   assign sum    = sum_ff;
   assign sq_sum = sq_ff;
   assign full   = (count_ff == CNT_W'(WINDOW_LEN));

endmodule

`default_nettype wire

FILE: hdl/ldwv_decide.sv
// ----------------------------------------------------------------------------
// ldwv_decide
// landing test on the full window and reference altitude lowering
// ----------------------------------------------------------------------------
`default_nettype none

module ldwv_decide import ldwv_pkg::*; #(
   parameter int WINDOW_LEN      = WINDOW_LEN_DEFAULT,
   parameter int CONFIRM_SECONDS = CONFIRM_SECONDS_DEFAULT
) (
   input  wire logic signed [ALT_W+$clog2(WINDOW_LEN)-1:0]  sum,
   input  wire logic [SQ_MAG_W+$clog2(WINDOW_LEN)-1:0]      sq_sum,
   input  wire logic                                        full,
   input  wire logic [SQ_MAG_W+2*$clog2(WINDOW_LEN+1)-1:0]  limit,
   input  wire cfg_type                                     cfg,
   input  wire logic signed [ALT_W-1:0]                     alt,
   input  wire logic [THRUST_W-1:0]                         thrust,
   input  wire logic signed [ALT_W-1:0]                     ref_now,
   output logic                                             landed,
   output logic                                             lowered,
   output logic signed [ALT_W-1:0]                          ref_next
);

   localparam int SUM_W = ALT_W + $clog2(WINDOW_LEN);
   localparam int CMP_W = SQ_MAG_W + 2 * $clog2(WINDOW_LEN + 1);

   logic [SUM_W-1:0]        sum_mag;
   logic [2*SUM_W-1:0]      sum_mag_sq;
   logic [CMP_W-1:0]        scaled_sq, spread;
   logic                    still, light;
   logic signed [ALT_W:0]   diff, step_ref;
   logic [ALT_W:0]          diff_mag;
   logic                    near, below;

   // n*sumsq - sum^2 < n^2*thr^2
   assign sum_mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign sum_mag_sq = sum_mag * sum_mag;
   assign scaled_sq  = CMP_W'(sq_sum) * CMP_W'(WINDOW_LEN);
   assign spread     = (scaled_sq > CMP_W'(sum_mag_sq)) ? scaled_sq - CMP_W'(sum_mag_sq) : '0;
   assign still      = spread < limit;
   assign light      = {thrust, 2'b00} < {2'b00, cfg.activation_thrust};
   assign landed     = full && still && light;

   assign diff     = $signed({alt[ALT_W-1], alt}) - $signed({ref_now[ALT_W-1], ref_now});
   assign diff_mag = diff[ALT_W] ? (ALT_W+1)'(-diff) : (ALT_W+1)'(diff);
   assign near     = (cfg.speed_threshold != '0)
                  && (diff_mag < (ALT_W+1)'(CONFIRM_SECONDS * MM_PER_SECOND));
   assign below    = alt < ref_now;
   assign lowered  = !landed && (below || near);

   assign step_ref = $signed({ref_now[ALT_W-1], ref_now}) - $signed((ALT_W+1)'(REF_STEP_MM));

   always_comb begin
      ref_next = ref_now;
      if (lowered) begin
         // saturate at the most negative altitude
         if (step_ref[ALT_W] != step_ref[ALT_W-1]) begin
            ref_next = {1'b1, {(ALT_W-1){1'b0}}};
         end else begin
            ref_next = step_ref[ALT_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/landing_detector_window_variance_core.sv
// ----------------------------------------------------------------------------
// landing_detector_window_variance_core
// sliding window altitude variance landing detector with reference lowering
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------------
//  req_chan  | in        | valid / ready        | altitude, thrust, sample_due
//  rsp_chan  | out       | valid / ready         | landed, reference_update, reference_altitude
//  csr_*     | in        | apb, pready always 1 | speed_threshold, activation_thrust,
//            |           |                      | initial_reference_altitude
//
//  one transaction per cycle sustained while rsp_chan is ready; each result passes
//  the input register, decision register and result register after its transaction is accepted
//  the loop that sets the rate is the window sums plus the variance compare, which
//  close combinationally within the cycle so the next transaction's update sees the landing clear
//  synchronous reset clears the pipeline, window counters, sums and registers;
//  no clearing pass, ring entries are only read after they were written
//  a stalled result holds; two more transactions wait behind it, then req ready drops
//
`default_nettype none

module landing_detector_window_variance_core import ldwv_pkg::*; #(
   parameter int WINDOW_LEN      = WINDOW_LEN_DEFAULT,
   parameter int CONFIRM_SECONDS = CONFIRM_SECONDS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ldwv_req_if.sink                   req_chan,
   ldwv_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SUM_W = ALT_W + $clog2(WINDOW_LEN);
   localparam int SQ_W  = SQ_MAG_W + $clog2(WINDOW_LEN);
   localparam int CMP_W = SQ_MAG_W + 2 * $clog2(WINDOW_LEN + 1);

   // configuration
   cfg_type                 cfg;
   logic [CMP_W-1:0]        limit;
   ref_load_type            ref_load;

   // pipeline handshake
   logic                    req_ready;
   logic                    req_fire;
   logic                    s1_fire;
   logic                    s2_take;
   logic                    out_load;

   // input register: transaction plus its squared altitude
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [ALT_W-1:0] s1_alt_ff;
   logic [THRUST_W-1:0]     s1_thrust_ff;
   logic                    s1_due_ff;
   logic [SQ_MAG_W-1:0]     s1_alt_sq_ff;
   logic signed [2*ALT_W-1:0] alt_sq_in;

   // decision register: transaction whose sums sit in the window
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [ALT_W-1:0] s2_alt_ff;
   logic [THRUST_W-1:0]     s2_thrust_ff;

   // window and decision
   logic signed [SUM_W-1:0] win_sum;
   logic [SQ_W-1:0]         win_sq;
   logic                    win_full;
   logic                    landed;
   logic                    lowered;
   logic signed [ALT_W-1:0] ref_next;

   // reference state and result register
   logic signed [ALT_W-1:0] ref_ff, ref_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    landed_ff;
   logic                    lowered_ff;
   logic signed [ALT_W-1:0] ref_out_ff;

   // ------------------------------------------------------------------
   // handshake chain, result register frees the stages behind it
   // ------------------------------------------------------------------
   assign out_load  = s2_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s2_take   = !s2_valid_ff || out_load;
   assign s1_fire   = s1_valid_ff && s2_take;
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign s2_valid_in  = s1_fire || (s2_valid_ff && !out_load);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   // square of the altitude taken before the input register
   assign alt_sq_in = req_chan.altitude * req_chan.altitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_alt_ff    <= req_chan.altitude;
         s1_thrust_ff <= req_chan.thrust;
         s1_due_ff    <= req_chan.sample_due;
         s1_alt_sq_ff <= alt_sq_in[SQ_MAG_W-1:0];
      end
      if (s1_fire) begin
         s2_alt_ff    <= s1_alt_ff;
         s2_thrust_ff <= s1_thrust_ff;
      end
      if (out_load) begin
         landed_ff  <= landed;
         lowered_ff <= lowered;
         ref_out_ff <= ref_next;
      end
   end

   // ------------------------------------------------------------------
   // register file
   // ------------------------------------------------------------------
   ldwv_csr #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .limit       (limit),
      .ref_load    (ref_load)
   );

   // ------------------------------------------------------------------
   // window update: push on a sample tick, clear on the landing decided
   // in the same cycle for the transaction ahead
   // ------------------------------------------------------------------
   ldwv_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .push   (s1_fire && s1_due_ff),
      .clear  (out_load && landed),
      .alt    (s1_alt_ff),
      .alt_sq (s1_alt_sq_ff),
      .sum    (win_sum),
      .sq_sum (win_sq),
      .full   (win_full)
   );

   // ------------------------------------------------------------------
   // landing test and reference step for the transaction in stage two
   // ------------------------------------------------------------------
   ldwv_decide #(
      .WINDOW_LEN      (WINDOW_LEN),
      .CONFIRM_SECONDS (CONFIRM_SECONDS)
   ) u_decide (
      .sum      (win_sum),
      .sq_sum   (win_sq),
      .full     (win_full),
      .limit    (limit),
      .cfg      (cfg),
      .alt      (s2_alt_ff),
      .thrust   (s2_thrust_ff),
      .ref_now  (ref_ff),
      .landed   (landed),
      .lowered  (lowered),
      .ref_next (ref_next)
   );

   // reference altitude, a register write reloads it; write it only while idle, the block does not enforce this
   always_comb begin
      ref_in = ref_ff;
      if (ref_load.load) begin
         ref_in = ref_load.value;
      end else if (out_load) begin
         ref_in = ref_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= INITIAL_REFERENCE_RESET;
      end else begin
         ref_ff <= ref_in;
      end
   end

   // result channel
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.landed             = landed_ff;
   assign rsp_chan.reference_update   = lowered_ff;
   assign rsp_chan.reference_altitude = ref_out_ff;

endmodule

`default_nettype wire

FILE: hdl/ldwv_checker.sv
// ----------------------------------------------------------------------------
// ldwv_checker
// port level checks on the result channel of the landing detector
// ----------------------------------------------------------------------------
`default_nettype none

module ldwv_checker import ldwv_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_landed,
   input wire logic                    rsp_reference_update,
   input wire logic signed [ALT_W-1:0] rsp_reference_altitude
);

   localparam int REF_TOP = (2 ** (ALT_W - 1) - 1) - REF_STEP_MM;

   logic last_landed_ff;

   // landed flag of the last delivered result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_landed_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_landed_ff <= rsp_landed;
      end
   end

   stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_landed)
         && $stable(rsp_reference_update) && $stable(rsp_reference_altitude))
      else $error("result changed while stalled");

   reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   landed_no_lower: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_landed && rsp_reference_update))
      else $error("landing and reference lowering on the same result");

   lowered_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reference_update |-> rsp_reference_altitude <= REF_TOP)
      else $error("lowered reference above the highest reachable value");

   no_double_landing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_landed |-> !last_landed_ff)
      else $error("two landings on consecutive results");

endmodule

bind landing_detector_window_variance_core ldwv_checker u_ldwv_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_landed             (rsp_chan.landed),
   .rsp_reference_update   (rsp_chan.reference_update),
   .rsp_reference_altitude (rsp_chan.reference_altitude)
);

`default_nettype wire
